// ----- design/sdf_pkg.sv -----
// Shared constants for the smooth damp follower: widths, Q16.16 constants,
// configuration register indexes and reset values.
// No dependencies.
package sdf_pkg;

    localparam int D_W       = 32;  // signed Q16.16 data word
    localparam int CFG_W     = 31;  // widest configuration register
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DELTA_TIME  = 2'd2;

    localparam logic [CFG_W-1:0] RST_SMOOTH_TIME = 31'd65536;
    localparam logic [CFG_W-1:0] RST_MAX_SPEED   = 31'h7FFF_FFFF;
    localparam logic [CFG_W-1:0] RST_DELTA_TIME  = 31'd1092;

    localparam logic signed [D_W-1:0] Q_ONE    = 32'sd65536;
    localparam logic [CFG_W-1:0]      MIN_SMOOTH = 31'd7;      // 0.0001
    localparam logic signed [D_W-1:0] DEADBAND = 32'sd131072;  // 2.0
    localparam logic signed [D_W-1:0] COEF_SQ  = 32'sd31457;   // 0.48
    localparam logic signed [D_W-1:0] COEF_CU  = 32'sd15401;   // 0.235

    localparam logic signed [D_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [D_W-1:0] S32_MIN = 32'sh8000_0000;

endpackage

// ----- design/sdf_if.sv -----
// Valid/ready channel interfaces for the smooth damp follower.
// Depends on sdf_pkg.
interface sdf_in_if;
    import sdf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic signed [D_W-1:0] current_position;
    logic signed [D_W-1:0] target_position;

    modport source (output valid, current_position, target_position, input ready);
    modport sink   (input valid, current_position, target_position, output ready);
endinterface

interface sdf_out_if;
    import sdf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic signed [D_W-1:0] smoothed_position;
    logic signed [D_W-1:0] new_velocity;
    logic                  snapped;

    modport source (output valid, smoothed_position, new_velocity, snapped, input ready);
    modport sink   (input valid, smoothed_position, new_velocity, snapped, output ready);
endinterface

// ----- design/smooth_damp_follower_core.sv -----
// Critically damped follower: one shared Q16.16 multiplier and a radix-4
// restoring divider under a one-hot sequencer. Depends on sdf_pkg, sdf_if.
//
//  channel  dir  handshake            payload
//  i_in     in   valid/ready          current_position, target_position
//  o_out    out  valid/ready          smoothed_position, new_velocity, snapped
//  i_cfg_*  in   write enable only    index, 31-bit data
//
// Each item runs through two divisions in the divider (omega and the exp term)
// and a chain of steps through the single multiplier and its adders before its
// result is loaded. i_in.ready is high only in idle, so the next item is taken
// only once the sequencer is back in idle after loading the last result.
// The result sits in an output register; a stalled output holds the sequencer
// in its last step until the register frees. Reset is synchronous, active low, and
// clears control state and the kept velocity and resets the configuration registers.
module smooth_damp_follower_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sdf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sdf_pkg::CFG_W-1:0]     i_cfg_data,
    sdf_in_if.sink                        i_in,
    sdf_out_if.source                     o_out
);
    import sdf_pkg::*;

    localparam int DIV_W     = 34;
    localparam int DIV_ITERS = DIV_W / 2;
    localparam int CNT_W     = $clog2(DIV_ITERS);
    localparam logic [DIV_W-1:0] DIVIDEND_OMEGA = DIV_W'(1) << 33;
    localparam logic [DIV_W-1:0] DIVIDEND_EXP   = DIV_W'(1) << 32;

    typedef enum logic [17:0] {
        S_IDLE = 18'(1 << 0),
        S_DIV1 = 18'(1 << 1),
        S_MX   = 18'(1 << 2),
        S_MX2  = 18'(1 << 3),
        S_MX3  = 18'(1 << 4),
        S_MT1  = 18'(1 << 5),
        S_MT2  = 18'(1 << 6),
        S_DEN  = 18'(1 << 7),
        S_CLMP = 18'(1 << 8),
        S_DIV2 = 18'(1 << 9),
        S_M1   = 18'(1 << 10),
        S_A1   = 18'(1 << 11),
        S_M2   = 18'(1 << 12),
        S_M3   = 18'(1 << 13),
        S_A2   = 18'(1 << 14),
        S_M4   = 18'(1 << 15),
        S_M5   = 18'(1 << 16),
        S_OUT  = 18'(1 << 17)
    } t_state;

    // Q16.16 product, magnitude truncated, saturated
    function automatic logic signed [D_W-1:0] qmul(input logic signed [D_W-1:0] a,
                                                   input logic signed [D_W-1:0] b);
        logic           neg;
        logic [D_W-1:0] ma;
        logic [D_W-1:0] mb;
        logic [63:0]    p;
        logic [47:0]    r;
        neg = a[D_W-1] ^ b[D_W-1];
        ma  = a[D_W-1] ? D_W'(-a) : D_W'(a);
        mb  = b[D_W-1] ? D_W'(-b) : D_W'(b);
        p   = 64'(ma) * 64'(mb);
        r   = p[63:16];
        if (neg) begin
            if (r >= 48'h8000_0000) qmul = S32_MIN;
            else                    qmul = -$signed(r[D_W-1:0]);
        end else begin
            if (r > 48'h7FFF_FFFF)  qmul = S32_MAX;
            else                    qmul = $signed(r[D_W-1:0]);
        end
    endfunction

    function automatic logic signed [D_W-1:0] sat33(input logic signed [D_W:0] v);
        if (v[D_W] != v[D_W-1]) sat33 = v[D_W] ? S32_MIN : S32_MAX;
        else                    sat33 = v[D_W-1:0];
    endfunction

    function automatic logic signed [D_W-1:0] sadd(input logic signed [D_W-1:0] a,
                                                   input logic signed [D_W-1:0] b);
        sadd = sat33({a[D_W-1], a} + {b[D_W-1], b});
    endfunction

    function automatic logic signed [D_W-1:0] ssub(input logic signed [D_W-1:0] a,
                                                   input logic signed [D_W-1:0] b);
        ssub = sat33({a[D_W-1], a} - {b[D_W-1], b});
    endfunction

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [D_W:0] div_step(input logic [D_W-1:0] rem,
                                              input logic           bit_in,
                                              input logic [D_W-1:0] d);
        logic [D_W:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, d}) div_step = {1'b1, D_W'(t - {1'b0, d})};
        else                div_step = {1'b0, t[D_W-1:0]};
    endfunction

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_smooth_time, r_max_speed, r_delta_time;
    logic signed [D_W-1:0] r_vel;

    logic signed [D_W-1:0] r_cur, r_tgt;
    logic signed [D_W-1:0] r_omega, r_x, r_x2, r_x3, r_den, r_ex, r_maxc;
    logic signed [D_W-1:0] r_chg, r_newt, r_tmp, r_p, r_a, r_b, r_vn;

    logic [DIV_W-1:0] r_dq;
    logic [D_W-1:0]   r_drem, r_dd;
    logic [CNT_W-1:0] r_dcnt;

    logic                  r_o_valid, r_o_snap;
    logic signed [D_W-1:0] r_o_pos, r_o_vel;

    logic [CFG_W-1:0]      w_st;
    logic signed [D_W-1:0] w_ma, w_mb, w_mres;
    logic [D_W:0]          w_s1, w_s2;
    logic [DIV_W-1:0]      w_dq_nx;
    logic                  w_div_last;
    logic signed [D_W:0]   w_diff, w_maxc33, w_tmc;
    logic signed [D_W-1:0] w_chg_clamp, w_chg, w_pos;
    logic                  w_snap, w_out_free;

    assign w_st = (r_smooth_time < MIN_SMOOTH) ? MIN_SMOOTH : r_smooth_time;

    // shared multiplier operand select
    always_comb begin
        w_ma = r_omega;
        w_mb = $signed({1'b0, r_delta_time});
        case (r_state)
            S_MX:  begin w_ma = r_omega;                    w_mb = $signed({1'b0, r_delta_time}); end
            S_MX2: begin w_ma = r_x;                        w_mb = r_x;     end
            S_MX3: begin w_ma = r_x2;                       w_mb = r_x;     end
            S_MT1: begin w_ma = COEF_SQ;                    w_mb = r_x2;    end
            S_MT2: begin w_ma = COEF_CU;                    w_mb = r_x3;    end
            S_DEN: begin w_ma = $signed({1'b0, r_max_speed}); w_mb = $signed({1'b0, w_st}); end
            S_M1:  begin w_ma = r_omega;                    w_mb = r_chg;   end
            S_M2:  begin w_ma = r_a;                        w_mb = $signed({1'b0, r_delta_time}); end
            S_M3:  begin w_ma = r_omega;                    w_mb = r_tmp;   end
            S_M4:  begin w_ma = r_b;                        w_mb = r_ex;    end
            S_M5:  begin w_ma = r_a;                        w_mb = r_ex;    end
            default: begin w_ma = r_omega;                  w_mb = r_x;     end
        endcase
    end
    assign w_mres = qmul(w_ma, w_mb);

    // divider, two quotient bits per cycle
    assign w_s1       = div_step(r_drem, r_dq[DIV_W-1], r_dd);
    assign w_s2       = div_step(w_s1[D_W-1:0], r_dq[DIV_W-2], r_dd);
    assign w_dq_nx    = {r_dq[DIV_W-3:0], w_s1[D_W], w_s2[D_W]};
    assign w_div_last = (r_dcnt == CNT_W'(DIV_ITERS - 1));

    // error clamp and deadband
    assign w_diff   = {r_cur[D_W-1], r_cur} - {r_tgt[D_W-1], r_tgt};
    assign w_maxc33 = {r_maxc[D_W-1], r_maxc};
    always_comb begin
        if (w_diff > w_maxc33)       w_chg_clamp = r_maxc;
        else if (w_diff < -w_maxc33) w_chg_clamp = -r_maxc;
        else                         w_chg_clamp = w_diff[D_W-1:0];
        if (w_chg_clamp > -DEADBAND && w_chg_clamp < DEADBAND) w_chg = '0;
        else                                                   w_chg = w_chg_clamp;
    end

    // final position and overshoot test
    assign w_pos      = sadd(r_newt, r_p);
    assign w_tmc      = {r_tgt[D_W-1], r_tgt} - {r_cur[D_W-1], r_cur};
    assign w_snap     = ((w_tmc > 0) == (w_pos > r_tgt));
    assign w_out_free = !r_o_valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in.valid) n_state = S_DIV1;
            S_DIV1: if (w_div_last) n_state = S_MX;
            S_MX:   n_state = S_MX2;
            S_MX2:  n_state = S_MX3;
            S_MX3:  n_state = S_MT1;
            S_MT1:  n_state = S_MT2;
            S_MT2:  n_state = S_DEN;
            S_DEN:  n_state = S_CLMP;
            S_CLMP: n_state = S_DIV2;
            S_DIV2: if (w_div_last) n_state = S_M1;
            S_M1:   n_state = S_A1;
            S_A1:   n_state = S_M2;
            S_M2:   n_state = S_M3;
            S_M3:   n_state = S_A2;
            S_A2:   n_state = S_M4;
            S_M4:   n_state = S_M5;
            S_M5:   n_state = S_OUT;
            S_OUT:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_smooth_time <= RST_SMOOTH_TIME;
            r_max_speed   <= RST_MAX_SPEED;
            r_delta_time  <= RST_DELTA_TIME;
            r_vel         <= '0;
            r_o_valid     <= 1'b0;
            r_dcnt        <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SMOOTH_TIME: r_smooth_time <= i_cfg_data;
                    REG_MAX_SPEED:   r_max_speed   <= i_cfg_data;
                    REG_DELTA_TIME:  r_delta_time  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_DIV1 || r_state == S_DIV2) r_dcnt <= r_dcnt + 1'b1;
            else                                        r_dcnt <= '0;
            if (r_o_valid && o_out.ready) r_o_valid <= 1'b0;
            if (r_state == S_OUT && w_out_free) begin
                r_o_valid <= 1'b1;
                r_vel     <= w_snap ? '0 : r_vn;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cur  <= i_in.current_position;
                r_tgt  <= i_in.target_position;
                r_dq   <= DIVIDEND_OMEGA;
                r_drem <= '0;
                r_dd   <= {1'b0, w_st};
            end
            S_DIV1: begin
                r_dq   <= w_dq_nx;
                r_drem <= w_s2[D_W-1:0];
                if (w_div_last) begin
                    if (|w_dq_nx[DIV_W-1:D_W-1]) r_omega <= S32_MAX;
                    else                         r_omega <= $signed(w_dq_nx[D_W-1:0]);
                end
            end
            S_MX:  r_x <= w_mres;
            S_MX2: begin
                r_x2  <= w_mres;
                r_den <= sadd(Q_ONE, r_x);
            end
            S_MX3: r_x3 <= w_mres;
            S_MT1: r_p  <= w_mres;
            S_MT2: begin
                r_p   <= w_mres;
                r_den <= sadd(r_den, r_p);
            end
            S_DEN: begin
                r_den  <= sadd(r_den, r_p);
                r_maxc <= w_mres;
            end
            S_CLMP: begin
                r_chg  <= w_chg;
                r_newt <= ssub(r_cur, w_chg);
                r_dq   <= DIVIDEND_EXP;
                r_drem <= '0;
                r_dd   <= r_den;   // den is at least 1.0, so positive
            end
            S_DIV2: begin
                r_dq   <= w_dq_nx;
                r_drem <= w_s2[D_W-1:0];
                if (w_div_last) r_ex <= $signed(w_dq_nx[D_W-1:0]);
            end
            S_M1: r_p   <= w_mres;
            S_A1: r_a   <= sadd(r_vel, r_p);
            S_M2: r_tmp <= w_mres;
            S_M3: begin
                r_p <= w_mres;
                r_a <= sadd(r_chg, r_tmp);
            end
            S_A2: r_b  <= ssub(r_vel, r_p);
            S_M4: r_vn <= w_mres;
            S_M5: r_p  <= w_mres;
            S_OUT: begin
                if (w_out_free) begin
                    r_o_pos  <= w_snap ? r_tgt : w_pos;
                    r_o_vel  <= w_snap ? '0 : r_vn;
                    r_o_snap <= w_snap;
                end
            end
            default: ;
        endcase
    end

    assign i_in.ready              = (r_state == S_IDLE);
    assign o_out.valid             = r_o_valid;
    assign o_out.smoothed_position = r_o_pos;
    assign o_out.new_velocity      = r_o_vel;
    assign o_out.snapped           = r_o_snap;

endmodule

// ----- design/sdf_checker.sv -----
// Port-level checks for smooth_damp_follower_core, attached by bind.
// Depends on sdf_pkg.
module sdf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic signed [sdf_pkg::D_W-1:0] i_out_smoothed_position,
    input logic signed [sdf_pkg::D_W-1:0] i_out_new_velocity,
    input logic                        i_out_snapped
);
    import sdf_pkg::*;

    // one item at a time: ready drops once an item is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready after accept");

    // a result cannot appear the cycle right after an item is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result too early");

    // a snapped item always carries zero velocity
    a_snap_zero_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_snapped |-> i_out_new_velocity == '0)
        else $error("snapped with velocity");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_smoothed_position))
        else $error("stalled output changed");

endmodule

bind smooth_damp_follower_core sdf_checker u_sdf_checker (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .i_in_valid             (i_in.valid),
    .i_in_ready             (i_in.ready),
    .i_out_valid            (o_out.valid),
    .i_out_ready            (o_out.ready),
    .i_out_smoothed_position(o_out.smoothed_position),
    .i_out_new_velocity     (o_out.new_velocity),
    .i_out_snapped          (o_out.snapped)
);
